>>> hdl/salwc_pkg.sv
// shared types, constants and control structs for the lru write-back cache model
// used by salwc_ctrl, salwc_dpath and the top level; no dependencies
package salwc_pkg;

  localparam int unsigned DEF_MAX_SET_BITS = 8;
  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_STAMP_WIDTH  = 32;
  localparam int unsigned BLOCK_BITS_MAX   = 16;
  localparam int unsigned ADDR_W           = 64;
  localparam int unsigned CNT_W            = 32;
  localparam int unsigned EVB_W            = 48;
  localparam int unsigned HELD_W           = 28;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic              was_hit;
    logic              did_evict;
    logic              evicted_was_dirty;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  evict_total;
    logic [EVB_W-1:0]  dirty_bytes_evicted;
    logic [HELD_W-1:0] dirty_bytes_held;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

>>> hdl/salwc_ctrl.sv
// controller: reset clearing sweep, request capture and commit sequencing
// depends on salwc_pkg
module salwc_ctrl import salwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   commit_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign commit_ok = !out_valid_r || out_ready;

  // commands
  always_comb begin
    cmd.clear_step = (state_r == ST_CLEAR);
    cmd.capture    = (state_r == ST_IDLE) && in_valid;
    cmd.commit     = (state_r == ST_CMP) && commit_ok;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      // a new result wins over the hand-off of the previous one
      if ((state_r == ST_CMP) && commit_ok) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (commit_ok) state_r <= ST_IDLE;
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

endmodule

>>> hdl/salwc_dpath.sv
// datapath: set memory, way compare, lru victim pick, counters and result register
// depends on salwc_pkg
module salwc_dpath import salwc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  in_t        in_data,
  input  logic [3:0] set_bits,
  input  logic [4:0] block_bits,
  input  logic [3:0] ways_in_use,
  output out_t       out_data
);

  localparam int unsigned SETS = 1 << MAX_SET_BITS;
  localparam int unsigned IW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned DCW  = $clog2(SETS * MAX_WAYS + 1);
  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

  // set memory, one row per set
  logic [MAX_WAYS-1:0]    mem_valid [SETS];
  logic [MAX_WAYS-1:0]    mem_dirty [SETS];
  logic [ADDR_W-1:0]      mem_tag   [SETS][MAX_WAYS];
  logic [STAMP_WIDTH-1:0] mem_stamp [SETS][MAX_WAYS];

  logic [MAX_WAYS-1:0]    rd_valid_r, rd_dirty_r;
  logic [ADDR_W-1:0]      rd_tag_r   [MAX_WAYS];
  logic [STAMP_WIDTH-1:0] rd_stamp_r [MAX_WAYS];

  logic              store_r;
  logic [ADDR_W-1:0] tag_r;
  logic [IW-1:0]     set_r;
  logic [IW-1:0]     clr_idx_r;

  logic [STAMP_WIDTH-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]       hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [EVB_W-1:0]       evb_r, evb_nxt;
  logic [DCW-1:0]         dcnt_r, dcnt_nxt;
  out_t                   out_r;

  // clamped configuration
  logic [3:0] sb;
  logic [4:0] bb;
  logic [4:0] ways;
  always_comb begin
    sb   = (32'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits;
    bb   = (32'(block_bits) > BLOCK_BITS_MAX) ? 5'(BLOCK_BITS_MAX) : block_bits;
    ways = (ways_in_use == 4'd0) ? 5'd1 : {1'b0, ways_in_use};
    if (32'(ways) > MAX_WAYS) ways = 5'(MAX_WAYS);
  end

  // address split
  logic [ADDR_W-1:0] off_addr;
  logic [IW-1:0]     set_mask;
  logic [IW-1:0]     in_set;
  logic [ADDR_W-1:0] in_tag;
  always_comb begin
    off_addr = in_data.address >> bb;
    set_mask = IW'(({{IW{1'b0}}, 1'b1} << sb) - 1'b1);
    in_set   = (MAX_SET_BITS > 0) ? (off_addr[IW-1:0] & set_mask) : '0;
    in_tag   = in_data.address >> (6'(sb) + 6'(bb));
  end

  assign sts.clear_last = (clr_idx_r == IW'(SETS - 1));

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_idx_r <= '0;
    else if (cmd.clear_step) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // way compare and victim choice
  logic [MAX_WAYS-1:0] hit_vec, free_vec;
  logic                hit, has_free;
  logic [WW-1:0]       hit_way, free_way, lru_way, sel;
  logic                evict, ev_dirty;
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    hit      = 1'b0;
    has_free = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w]  = (5'(w) < ways) && rd_valid_r[w] && (rd_tag_r[w] == tag_r);
      free_vec[w] = (5'(w) < ways) && !rd_valid_r[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_way = WW'(w);
      end
      if (free_vec[w]) begin
        has_free = 1'b1;
        free_way = WW'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((5'(w) < ways) && (rd_stamp_r[w] < rd_stamp_r[lru_way])) lru_way = WW'(w);
    end
    priority if (hit) sel = hit_way;
    else if (has_free) sel = free_way;
    else sel = lru_way;
    evict    = !hit && !has_free;
    ev_dirty = evict && rd_dirty_r[sel];
  end

  // new row and counter updates
  logic [MAX_WAYS-1:0] new_valid, new_dirty;
  logic [EVB_W:0]      evb_sum;
  logic [EVB_W-1:0]    blk;
  logic [EVB_W-1:0]    held_ext;
  always_comb begin
    clock_nxt = (clock_r == STAMP_MAX) ? clock_r : clock_r + 1'b1;
    new_valid = rd_valid_r;
    new_dirty = rd_dirty_r;
    new_valid[sel] = 1'b1;
    new_dirty[sel] = hit ? (rd_dirty_r[sel] | store_r) : store_r;
    dcnt_nxt = dcnt_r;
    if (hit) begin
      if (store_r && !rd_dirty_r[sel]) dcnt_nxt = dcnt_r + 1'b1;
    end else begin
      dcnt_nxt = dcnt_r - DCW'(rd_valid_r[sel] & rd_dirty_r[sel]) + DCW'(store_r);
    end
    blk     = EVB_W'(1) << bb;
    evb_sum = {1'b0, evb_r} + {1'b0, blk};
    evb_nxt = ev_dirty ? (evb_sum[EVB_W] ? '1 : evb_sum[EVB_W-1:0]) : evb_r;
    held_ext = EVB_W'(dcnt_nxt) << bb;
  end

  // memory read at capture, write at commit or sweep
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_valid_r <= mem_valid[in_set];
      rd_dirty_r <= mem_dirty[in_set];
      for (int w = 0; w < MAX_WAYS; w++) begin
        rd_tag_r[w]   <= mem_tag[in_set][w];
        rd_stamp_r[w] <= mem_stamp[in_set][w];
      end
      store_r <= (in_data.req_type == REQ_STORE);
      tag_r   <= in_tag;
      set_r   <= in_set;
    end
    if (cmd.clear_step) begin
      mem_valid[clr_idx_r] <= '0;
      mem_dirty[clr_idx_r] <= '0;
    end else if (cmd.commit) begin
      mem_valid[set_r]      <= new_valid;
      mem_dirty[set_r]      <= new_dirty;
      mem_tag[set_r][sel]   <= tag_r;
      mem_stamp[set_r][sel] <= clock_nxt;
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      evb_r       <= '0;
      dcnt_r      <= '0;
    end else if (cmd.commit) begin
      clock_r <= clock_nxt;
      if (hit && hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + 1'b1;
      if (!hit && miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + 1'b1;
      if (evict && evict_cnt_r != '1) evict_cnt_r <= evict_cnt_r + 1'b1;
      evb_r  <= evb_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.was_hit             <= hit;
      out_r.did_evict           <= evict;
      out_r.evicted_was_dirty   <= ev_dirty;
      out_r.hit_total           <= (hit && hit_cnt_r != '1) ? hit_cnt_r + 1'b1 : hit_cnt_r;
      out_r.miss_total          <= (!hit && miss_cnt_r != '1) ? miss_cnt_r + 1'b1
                                                               : miss_cnt_r;
      out_r.evict_total         <= (evict && evict_cnt_r != '1) ? evict_cnt_r + 1'b1
                                                                 : evict_cnt_r;
      out_r.dirty_bytes_evicted <= evb_nxt;
      out_r.dirty_bytes_held    <= held_ext[HELD_W-1:0];
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/set_assoc_lru_writeback_cache_sim_unit.sv
// top level: configuration registers, controller and datapath of the lru cache model
// depends on salwc_pkg, salwc_ctrl, salwc_dpath
// a request's set row is read when it is accepted; its result is registered at commit,
// which waits while an earlier result is stalled; a new request is taken only after commit
// reset: a sweep over all 2**MAX_SET_BITS sets clears valid and dirty bits of every set;
// no request is accepted during it, configuration writes are taken as usual
module set_assoc_lru_writeback_cache_sim_unit import salwc_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = DEF_MAX_WAYS,
  parameter int unsigned STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;
  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SET_BITS:   set_bits_r   <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits_r <= pwdata[4:0];
        REG_WAYS:       ways_r       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_SET_BITS:   prdata = {28'd0, set_bits_r};
      REG_BLOCK_BITS: prdata = {27'd0, block_bits_r};
      REG_WAYS:       prdata = {28'd0, ways_r};
      default:        prdata = '0;
    endcase
  end

  salwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  salwc_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .set_bits    (set_bits_r),
    .block_bits  (block_bits_r),
    .ways_in_use (ways_r),
    .out_data    (out_data)
  );

endmodule

>>> hdl/salwc_checker.sv
// port-level checks for the lru cache model, bound to the top level
// depends on salwc_pkg
module salwc_checker import salwc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // a hit never replaces a line
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.was_hit && out_data.did_evict))
    else $error("hit with eviction");

  // a dirty eviction is an eviction
  a_dirty_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted_was_dirty |-> out_data.did_evict)
    else $error("dirty flag without eviction");

endmodule

bind set_assoc_lru_writeback_cache_sim_unit salwc_checker u_salwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
